/* rtl/core/cose_pkg.sv */
package cose_pkg;

	localparam int FILE_W        = 4;
	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 3;
	localparam int LOG2_W        = 3;
	localparam int SYM_W         = 8;
	localparam int SYM_LEN_W     = 4;
	localparam int CFG_ADDR_W    = 1;
	localparam int CFG_DATA_W    = 3;

	localparam int DEF_MAX_FILES     = 16;
	localparam int DEF_POSITION_BITS = 16;

	localparam logic [LOG2_W-1:0] FILES_LOG2_RST = 3'd1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FILES_LOG2     = 1'b0,
		REG_DIRECTION_MODE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic                 step;
		logic [SYM_W-1:0]     sym;
		logic [SYM_LEN_W-1:0] len;
	} pk_req_t;

	typedef struct packed {
		logic              emit;
		logic [BYTE_W-1:0] data;
	} pk_res_t;

endpackage

/* rtl/core/cose_packer.sv */
module cose_packer (
	input  logic             clk,
	input  logic             arst_n,
	input  cose_pkg::pk_req_t req,
	output cose_pkg::pk_res_t res
);
	import cose_pkg::*;

	localparam int COMB_W = 2 * BYTE_W - 1;

	logic [BYTE_W-1:0]    acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SYM_W-1:0]     sym_m;
	logic [SYM_LEN_W-1:0] total;
	logic [COMB_W-1:0]    comb;
	logic [CNT_W-1:0]     shamt;
	logic [BYTE_W-1:0]    acc_d;
	logic [CNT_W-1:0]     cnt_d;

	always_comb begin
		sym_m = req.sym & SYM_W'((9'(1) << req.len) - 9'(1));
		total = SYM_LEN_W'(cnt_q) + req.len;
		// held bits on top, new symbol below; held bits never exceed 7
		comb  = (COMB_W'(acc_q) << req.len) | COMB_W'(sym_m);
		shamt = total[CNT_W-1:0];
		res.emit = req.step && total[SYM_LEN_W-1];
		res.data = BYTE_W'(comb >> shamt);
		if (total[SYM_LEN_W-1]) begin
			acc_d = BYTE_W'(comb & ((COMB_W'(1) << shamt) - COMB_W'(1)));
		end else begin
			acc_d = comb[BYTE_W-1:0];
		end
		cnt_d = total[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (req.step) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

/* rtl/core/cluster_order_symbol_extract.sv */
// Cluster-order symbol extractor.
// Input stream (s_axis_*): one beat per storage cluster in ascending cluster
// order, carrying the owning file number and the cluster's position in that
// file's chain. Output stream (m_axis_*): recovered message bytes, MSB first.
// Each input beat yields zero or one output beat.
// Config port: cfg_we/cfg_addr/cfg_wdata, index 0 = files_log2, 1 =
// direction_mode; write only while the block is idle.
// A beat that is accepted sits in the input stage until the output register can
// take it; it is then resolved and its byte (if any) is presented on m_axis.
// Throughput: one beat per cycle while the receiver keeps up; the per-file last-position
// memory is read when a beat is accepted and, in direction mode, written when it leaves
// the input stage, with a forward path for back-to-back beats of the same file.
// Reset clears the packed bit count, the per-file seen flags and restores
// files_log2 = 1, direction_mode = 0. A stalled receiver holds the byte in the
// output register; s_axis_tready drops only once both the output register and
// the input stage are full.
module cluster_order_symbol_extract #(
	parameter int MAX_FILES     = cose_pkg::DEF_MAX_FILES,
	parameter int POSITION_BITS = cose_pkg::DEF_POSITION_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// file_number, position_in_file
	input  logic [((cose_pkg::FILE_W + POSITION_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// message_byte
	output logic [cose_pkg::BYTE_W-1:0]             m_axis_tdata,
	input  logic                                    cfg_we,
	input  logic [cose_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [cose_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import cose_pkg::*;

	localparam int SLOT_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int POS_W  = POSITION_BITS;

	logic [LOG2_W-1:0] files_log2_q;
	logic              dir_mode_q;

	logic [FILE_W-1:0] in_file;
	logic [POS_W-1:0]  in_pos;
	logic [FILE_W-1:0] fmod;
	logic [SLOT_W-1:0] in_slot;
	logic              accept;

	logic              valid_s1;
	logic [FILE_W-1:0] file_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [POS_W-1:0]  rd_s1;
	logic              fwd_s1;
	logic [POS_W-1:0]  fwd_pos_s1;
	logic              fire_s1;

	logic [POS_W-1:0]  last_pos_mem [MAX_FILES];
	logic [MAX_FILES-1:0] seen_q;

	logic [POS_W-1:0]  prev_pos;
	logic              seen;
	logic              dbit;
	pk_req_t           preq;
	pk_res_t           pres;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;

	assign in_file = s_axis_tdata[FILE_W-1:0];
	assign in_pos  = s_axis_tdata[FILE_W +: POS_W];

	// file number reduced modulo the slot count
	always_comb begin
		fmod = in_file;
		for (int i = 0; i < 8; i++) begin
			if (int'(fmod) >= MAX_FILES) begin
				fmod = fmod - FILE_W'(MAX_FILES);
			end
		end
		in_slot = SLOT_W'(fmod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			files_log2_q <= FILES_LOG2_RST;
			dir_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_addr))
				REG_FILES_LOG2:     files_log2_q <= cfg_wdata[LOG2_W-1:0];
				REG_DIRECTION_MODE: dir_mode_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign fire_s1       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			file_s1    <= in_file;
			pos_s1     <= in_pos;
			slot_s1    <= in_slot;
			// beat leaving now writes the slot this beat reads
			fwd_s1     <= fire_s1 && dir_mode_q && (slot_s1 == in_slot);
			fwd_pos_s1 <= pos_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= last_pos_mem[in_slot];
		end
		if (fire_s1 && dir_mode_q) begin
			last_pos_mem[slot_s1] <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (fire_s1 && dir_mode_q) begin
			seen_q[slot_s1] <= 1'b1;
		end
	end

	always_comb begin
		prev_pos = fwd_s1 ? fwd_pos_s1 : rd_s1;
		seen     = seen_q[slot_s1];
		dbit     = !(pos_s1 > prev_pos);
		preq.step = fire_s1 && (!dir_mode_q || seen);
		if (dir_mode_q) begin
			preq.sym = SYM_W'({file_s1, dbit});
		end else begin
			preq.sym = SYM_W'(file_s1);
		end
		preq.len = SYM_LEN_W'(files_log2_q) + SYM_LEN_W'(dir_mode_q);
	end

	cose_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.res    (pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= pres.emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && pres.emit) begin
			out_data_q <= pres.data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import cose_pkg::*;

	localparam int DATA_W      = ((FILE_W + DEF_POSITION_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;   // file_number, position_in_file, zero fill
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [BYTE_W-1:0]     m_axis_tdata;   // message_byte
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cluster_order_symbol_extract uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// shadow of the block: config, per-file order state, bit packer
	logic [LOG2_W-1:0]    sym_bits_cfg;
	logic                 dir_mode_cfg;
	logic                 file_seen_q [DEF_MAX_FILES];
	logic [15:0]          last_pos_q  [DEF_MAX_FILES];
	logic [BYTE_W-1:0]    pack_acc;
	int                   pack_cnt;
	logic [BYTE_W-1:0]    pending_bytes [$];

	// stimulus-side chain positions, used to build ascending file chains
	logic [15:0]          chain_pos [DEF_MAX_FILES];

	int    error_count;
	int    cycle_count;
	bit    tx_idle;
	bit    rx_idle;
	bit    rx_hold;

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		error_count++;
		$display("[%0t] mismatch: %s got %02h expected %02h", $time, what, got, want);
	endtask

	function automatic void predict_cluster(input logic [3:0] file, input logic [15:0] pos);
		logic [8:0] sym;
		int         width;
		width = int'(sym_bits_cfg) + int'(dir_mode_cfg);
		if (dir_mode_cfg) begin
			if (!file_seen_q[file]) begin
				file_seen_q[file] = 1'b1;
				last_pos_q[file] = pos;
				return;
			end
			// equal position counts as not above
			sym = {4'b0, file, (pos > last_pos_q[file]) ? 1'b0 : 1'b1};
			last_pos_q[file] = pos;
		end else begin
			sym = {5'b0, file};
		end
		for (int k = 0; k < width; k++) begin
			pack_acc = {pack_acc[6:0], sym[width - 1 - k]};
			pack_cnt++;
			if (pack_cnt == 8) begin
				pending_bytes.push_back(pack_acc);
				pack_acc = '0;
				pack_cnt = 0;
			end
		end
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_FILES_LOG2)
			sym_bits_cfg = val;
		else
			dir_mode_cfg = val[0];
	endtask

	task automatic send_cluster(input logic [3:0] file, input logic [15:0] pos);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = '0;
		s_axis_tdata[3:0] = file;
		s_axis_tdata[19:4] = pos;
		do @(posedge clk); while (!s_axis_tready);
		predict_cluster(file, pos);
		chain_pos[file] = pos;
	endtask

	// drop valid, wait for every expected byte, then let the pipe empty
	task automatic drain;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic random_cluster;
		logic [3:0]  file;
		logic [15:0] pos;
		int          kind;
		file = 4'($urandom_range(0, 15));
		kind = $urandom_range(0, 9);
		if (kind < 7)
			pos = chain_pos[file] + 16'($urandom_range(1, 300));
		else if (kind == 7)
			pos = chain_pos[file];
		else if (kind == 8)
			pos = 16'($urandom);
		else
			pos = chain_pos[file] - 16'($urandom_range(1, 300));
		send_cluster(file, pos);
	endtask

	// receiver: random wait per beat, optional long hold-off
	initial begin : receiver
		int wait_cycles;
		m_axis_tready = 1'b0;
		forever begin
			wait_cycles = rx_idle ? $urandom_range(0, 17) : 0;
			@(negedge clk);
			while (wait_cycles > 0 || rx_hold) begin
				m_axis_tready = 1'b0;
				if (wait_cycles > 0)
					wait_cycles--;
				@(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cluster_order_symbol_extract verification failed");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0)
				report_mismatch("unexpected message_byte", m_axis_tdata, 8'h00);
			else if (m_axis_tdata !== pending_bytes[0])
				report_mismatch("message_byte", m_axis_tdata, pending_bytes.pop_front());
			else
				void'(pending_bytes.pop_front());
		end
	end

	task automatic test_plain_packing;
		// reset config: 1 bit per symbol
		send_cluster(4'd0, 16'd0);
		send_cluster(4'd15, 16'hFFFF);
		send_cluster(4'd1, 16'd1);
		send_cluster(4'd2, 16'h8000);
		drain();
		write_reg(REG_FILES_LOG2, 3'd4);
		send_cluster(4'd15, 16'd0);
		send_cluster(4'd0, 16'hFFFF);
		drain();
	endtask

	task automatic test_zero_width;
		write_reg(REG_FILES_LOG2, 3'd0);
		write_reg(REG_DIRECTION_MODE, 3'd0);
		send_cluster(4'd15, 16'hFFFF);
		send_cluster(4'd9, 16'd3);
		drain();
	endtask

	task automatic test_direction_bits;
		write_reg(REG_FILES_LOG2, 3'd4);
		write_reg(REG_DIRECTION_MODE, 3'd1);
		send_cluster(4'd3, 16'd0);       // first sight of a file: no symbol
		send_cluster(4'd3, 16'hFFFF);    // above
		send_cluster(4'd3, 16'hFFFF);    // equal
		send_cluster(4'd3, 16'd0);       // below
		send_cluster(4'd15, 16'hFFFF);
		send_cluster(4'd15, 16'd0);
		send_cluster(4'd0, 16'd7);
		send_cluster(4'd0, 16'd8);
		drain();
	endtask

	task automatic test_wide_symbols;
		// 7 + direction bit fills a whole byte per symbol
		write_reg(REG_FILES_LOG2, 3'd7);
		send_cluster(4'd15, 16'd9);
		send_cluster(4'd3, 16'd1);
		drain();
		write_reg(REG_DIRECTION_MODE, 3'd0);
		write_reg(REG_FILES_LOG2, 3'd5);
		send_cluster(4'd10, 16'd100);
		send_cluster(4'd5, 16'd200);
		drain();
	endtask

	task automatic test_backpressure;
		write_reg(REG_FILES_LOG2, 3'd4);
		write_reg(REG_DIRECTION_MODE, 3'd0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		fork
			begin
				rx_hold = 1'b1;
				repeat (120) @(posedge clk);
				rx_hold = 1'b0;
			end
			repeat (40) random_cluster();
		join
		drain();
	endtask

	task automatic test_random_settings;
		logic [2:0] log2_set [11] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6,
			3'd4, 3'd7, 3'd0};
		logic       dir_set  [11] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
			1'b0, 1'b0, 1'b0};
		int         n_items;
		for (int ph = 0; ph < 11; ph++) begin
			write_reg(REG_FILES_LOG2, log2_set[ph]);
			write_reg(REG_DIRECTION_MODE, {2'b0, dir_set[ph]});
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			// zero-width phase emits nothing, keep it short
			n_items = (log2_set[ph] == 3'd0 && !dir_set[ph]) ? 20 : 165;
			repeat (n_items) random_cluster();
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_FILES_LOG2;
		cfg_wdata = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 1'b0;
		error_count = 0;
		cycle_count = 0;
		sym_bits_cfg = FILES_LOG2_RST;
		dir_mode_cfg = 1'b0;
		pack_acc = '0;
		pack_cnt = 0;
		for (int i = 0; i < DEF_MAX_FILES; i++) begin
			file_seen_q[i] = 1'b0;
			last_pos_q[i] = '0;
			chain_pos[i] = 16'($urandom);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_packing();
		test_zero_width();
		test_direction_bits();
		test_wide_symbols();
		test_backpressure();
		test_random_settings();

		drain();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("cluster_order_symbol_extract verification clean");
		else
			$display("cluster_order_symbol_extract verification failed");
		$finish;
	end

endmodule
